// ===== hdl/cbm_pkg.sv =====
// Package for the cartridge bank mapper: widths, register indexes, decode offsets,
// reset tables and the result record type.
// No dependencies; compiled first.
package cbm_pkg;

    localparam int CpuAddrW  = 16;
    localparam int PpuAddrW  = 14;
    localparam int DataW     = 8;
    localparam int PrgAddrW  = 21;
    localparam int ChrAddrW  = 18;
    localparam int CfgIndexW = 2;
    localparam int CfgDataW  = 8;
    localparam int PrgBanks  = 4;
    localparam int ChrBanks  = 8;

    typedef logic [DataW-1:0] bank_t;

    // Configuration register indexes
    localparam logic [CfgIndexW-1:0] REG_PRG_BANK_MASK = 2'd0;
    localparam logic [CfgIndexW-1:0] REG_CHR_BANK_MASK = 2'd1;

    // Command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Register page and offsets within it
    localparam logic [3:0]  REG_PAGE        = 4'h4;
    localparam logic [11:0] OFF_MIRROR_ONE  = 12'h2FE;
    localparam logic [11:0] OFF_MIRROR_TWO  = 12'h2FF;
    localparam logic [11:0] OFF_IRQ_ACK     = 12'h501;
    localparam logic [11:0] OFF_COUNT_LOW   = 12'h502;
    localparam logic [11:0] OFF_COUNT_HIGH  = 12'h503;
    localparam logic [11:0] OFF_PRG_FIRST   = 12'h504;
    localparam logic [11:0] OFF_PRG_LAST    = 12'h507;
    localparam logic [11:0] OFF_CHR_FIRST   = 12'h510;
    localparam logic [11:0] OFF_CHR_LAST    = 12'h517;

    // Mirroring modes
    localparam logic [1:0] MIRROR_PAGE0      = 2'd0;
    localparam logic [1:0] MIRROR_PAGE1      = 2'd1;
    localparam logic [1:0] MIRROR_VERTICAL   = 2'd2;
    localparam logic [1:0] MIRROR_HORIZONTAL = 2'd3;

    localparam logic [15:0] COUNT_LAST = 16'hFFFF;

    localparam logic [DataW-1:0] PRG_MASK_RESET = 8'd31;
    localparam logic [DataW-1:0] CHR_MASK_RESET = 8'd255;

    localparam bank_t PRG_BANK_RESET [PrgBanks] = '{8'd0, 8'd1, 8'd254, 8'd255};

    typedef struct packed {
        logic                irq_line;
        logic                prg_selected;
        logic [PrgAddrW-1:0] prg_rom_address;
        logic [ChrAddrW-1:0] chr_rom_address;
        logic                nametable_page;
        logic [1:0]          mirror_mode;
    } result_t;

endpackage

// ===== hdl/cbm_request_if.sv =====
// Request channel of the cartridge bank mapper: one CPU cycle per request.
// Depends on cbm_pkg for field widths.
interface cbm_request_if
    import cbm_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic                command;
    logic [CpuAddrW-1:0] cpu_address;
    logic [DataW-1:0]    write_data;
    logic [PpuAddrW-1:0] ppu_address;

    modport source (output valid, command, cpu_address, write_data, ppu_address,
                    input ready);
    modport sink   (input valid, command, cpu_address, write_data, ppu_address,
                    output ready);
endinterface

// ===== hdl/cbm_result_if.sv =====
// Result channel of the cartridge bank mapper: translated addresses and IRQ state.
// Depends on cbm_pkg for field widths.
interface cbm_result_if
    import cbm_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic                irq_line;
    logic                prg_selected;
    logic [PrgAddrW-1:0] prg_rom_address;
    logic [ChrAddrW-1:0] chr_rom_address;
    logic                nametable_page;
    logic [1:0]          mirror_mode;

    modport source (output valid, irq_line, prg_selected, prg_rom_address,
                    chr_rom_address, nametable_page, mirror_mode,
                    input ready);
    modport sink   (input valid, irq_line, prg_selected, prg_rom_address,
                    chr_rom_address, nametable_page, mirror_mode,
                    output ready);
endinterface

// ===== hdl/cartridge_bank_mapper_with_irq_unit.sv =====
// Top level of the cartridge bank mapper with cycle-counting IRQ.
// Depends on cbm_pkg, cbm_request_if and cbm_result_if.
//
//   Channel    Direction  Handshake        Carries
//   request    in         valid/ready      command, cpu_address, write_data, ppu_address
//   result     out        valid/ready      irq_line, prg/chr addresses, page, mirror mode
//   cfg        in         cfg_write_en     cfg_index, cfg_data (bank masks)
//
// One request is taken every clock cycle while request.ready is high; its result is
// registered after the decode and translate logic, in the result or the skid register.
// Reset (rst_n low, asynchronous) restores the bank tables, mirroring and IRQ state.
// A two-entry output stage (result register plus skid register) lets a request be
// accepted while the previous result is still waiting; request.ready only falls once
// both entries are full, and no request is lost or repeated under stalls.
module cartridge_bank_mapper_with_irq_unit
    import cbm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cbm_request_if.sink          request,
    cbm_result_if.source         result,
    input  logic                 cfg_write_en,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    // Configuration registers
    logic [DataW-1:0] prg_mask_reg;
    logic [DataW-1:0] chr_mask_reg;

    // Mapper state
    bank_t       prg_banks_reg [PrgBanks];
    bank_t       chr_banks_reg [ChrBanks];
    logic [1:0]  mirroring_reg;
    logic [15:0] counter_reg;
    logic        irq_enable_reg;
    logic        irq_pending_reg;

    bank_t       prg_banks_next [PrgBanks];
    bank_t       chr_banks_next [ChrBanks];
    logic [1:0]  mirroring_next;
    logic [15:0] counter_next;
    logic        irq_enable_next;
    logic        irq_pending_next;

    // Output stage: main result register and a skid register behind it
    result_t main_reg;
    result_t skid_reg;
    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t fresh;

    logic        accept;
    logic        taken;
    logic [11:0] offset;
    logic        in_page;
    bank_t       prg_bank;
    bank_t       chr_bank;

    assign request.ready = !skid_valid_reg;
    assign accept        = request.valid && !skid_valid_reg;
    assign taken         = main_valid_reg && result.ready;

    assign offset  = request.cpu_address[11:0];
    assign in_page = (request.cpu_address[15:12] == REG_PAGE);

    // The configuration registers may be rewritten only while the block is idle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_mask_reg <= PRG_MASK_RESET;
            chr_mask_reg <= CHR_MASK_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_PRG_BANK_MASK: prg_mask_reg <= cfg_data;
                REG_CHR_BANK_MASK: chr_mask_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Next state for one CPU cycle: either a register write is decoded, or the counter
    // advances while enabled. A counter of zero is parked and does not count; stepping
    // past the last value raises the interrupt and wraps the counter to zero.
    always_comb
    begin
        prg_banks_next   = prg_banks_reg;
        chr_banks_next   = chr_banks_reg;
        mirroring_next   = mirroring_reg;
        counter_next     = counter_reg;
        irq_enable_next  = irq_enable_reg;
        irq_pending_next = irq_pending_reg;

        if (request.command == CMD_WRITE)
        begin
            if (in_page)
            begin
                if (offset == OFF_MIRROR_ONE)
                begin
                    mirroring_next = request.write_data[4] ? MIRROR_PAGE1 : MIRROR_PAGE0;
                end
                else if (offset == OFF_MIRROR_TWO)
                begin
                    mirroring_next = request.write_data[4] ? MIRROR_HORIZONTAL
                                                           : MIRROR_VERTICAL;
                end
                else if (offset == OFF_IRQ_ACK)
                begin
                    irq_enable_next  = 1'b0;
                    irq_pending_next = 1'b0;
                end
                else if (offset == OFF_COUNT_LOW)
                begin
                    counter_next[7:0] = request.write_data;
                    irq_pending_next  = 1'b0;
                end
                else if (offset == OFF_COUNT_HIGH)
                begin
                    counter_next[15:8] = request.write_data;
                    irq_enable_next    = 1'b1;
                    irq_pending_next   = 1'b0;
                end
                else if (offset inside {[OFF_PRG_FIRST:OFF_PRG_LAST]})
                begin
                    prg_banks_next[offset[1:0]] = request.write_data;
                end
                else if (offset inside {[OFF_CHR_FIRST:OFF_CHR_LAST]})
                begin
                    chr_banks_next[offset[2:0]] = request.write_data;
                end
            end
        end
        else if (irq_enable_reg && (counter_reg != '0))
        begin
            if (counter_reg == COUNT_LAST)
            begin
                irq_pending_next = 1'b1;
            end
            counter_next = counter_reg + 16'd1;
        end
    end

    // Address translation uses the state as it stands after this cycle's write.
    assign prg_bank = prg_banks_next[request.cpu_address[14:13]] & prg_mask_reg;
    assign chr_bank = chr_banks_next[request.ppu_address[12:10]] & chr_mask_reg;

    always_comb
    begin
        fresh                 = '0;
        fresh.irq_line        = irq_pending_next;
        fresh.mirror_mode     = mirroring_next;
        fresh.prg_selected    = request.cpu_address[15];
        if (request.cpu_address[15])
        begin
            fresh.prg_rom_address = {prg_bank, request.cpu_address[12:0]};
        end
        if (!request.ppu_address[13])
        begin
            fresh.chr_rom_address = {chr_bank, request.ppu_address[9:0]};
        end
        else
        begin
            case (mirroring_next)
                MIRROR_PAGE0:      fresh.nametable_page = 1'b0;
                MIRROR_PAGE1:      fresh.nametable_page = 1'b1;
                MIRROR_VERTICAL:   fresh.nametable_page = request.ppu_address[10];
                MIRROR_HORIZONTAL: fresh.nametable_page = request.ppu_address[11];
                default:           fresh.nametable_page = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_banks_reg   <= PRG_BANK_RESET;
            for (int i = 0; i < ChrBanks; i++)
            begin
                chr_banks_reg[i] <= DataW'(i);
            end
            mirroring_reg   <= MIRROR_PAGE0;
            counter_reg     <= '0;
            irq_enable_reg  <= 1'b0;
            irq_pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            prg_banks_reg   <= prg_banks_next;
            chr_banks_reg   <= chr_banks_next;
            mirroring_reg   <= mirroring_next;
            counter_reg     <= counter_next;
            irq_enable_reg  <= irq_enable_next;
            irq_pending_reg <= irq_pending_next;
        end
    end

    // Output stage control. When the result register is drained, the skid entry
    // (if any) moves forward; otherwise a fresh result fills whichever entry is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (taken)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (taken)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (accept)
            begin
                main_reg <= fresh;
            end
        end
        else if (accept)
        begin
            if (main_valid_reg)
            begin
                skid_reg <= fresh;
            end
            else
            begin
                main_reg <= fresh;
            end
        end
    end

    assign result.valid           = main_valid_reg;
    assign result.irq_line        = main_reg.irq_line;
    assign result.prg_selected    = main_reg.prg_selected;
    assign result.prg_rom_address = main_reg.prg_rom_address;
    assign result.chr_rom_address = main_reg.chr_rom_address;
    assign result.nametable_page  = main_reg.nametable_page;
    assign result.mirror_mode     = main_reg.mirror_mode;

endmodule

// ===== hdl/cbm_checker.sv =====
// Port-level checks for the cartridge bank mapper, attached by a bind statement.
// Depends on cbm_pkg and on cartridge_bank_mapper_with_irq_unit.
module cbm_checker
    import cbm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic [CpuAddrW-1:0] req_cpu_address,
    input logic                res_valid,
    input logic                res_ready,
    input logic                res_prg_selected,
    input logic [PrgAddrW-1:0] res_prg_rom_address
);

    // A result that is not taken stays offered with its PRG address unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_prg_rom_address))
        else $error("stalled result changed or vanished");

    // With no result held, the block must be able to take a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> req_ready)
        else $error("request refused with empty output stage");

    // A request taken into an empty output stage appears as a result next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !res_valid |=> res_valid)
        else $error("accepted request did not produce a result");

    // That result reports no PRG selection for a CPU address below the ROM window.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !res_valid && !req_cpu_address[15]
        |=> !res_prg_selected && (res_prg_rom_address == '0))
        else $error("PRG selected below the ROM window");

endmodule

bind cartridge_bank_mapper_with_irq_unit cbm_checker u_cbm_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (request.valid),
    .req_ready           (request.ready),
    .req_cpu_address     (request.cpu_address),
    .res_valid           (result.valid),
    .res_ready           (result.ready),
    .res_prg_selected    (result.prg_selected),
    .res_prg_rom_address (result.prg_rom_address)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the cartridge bank mapper with cycle-counting IRQ.
// Depends on cbm_pkg, cbm_request_if, cbm_result_if and cartridge_bank_mapper_with_irq_unit.
// A queue-fed driver, a predicting monitor and random handshake stalls check every result.
module tb_top;
    import cbm_pkg::*;

    // Offsets the decoder must ignore, and a bound below which it acts on no offset.
    localparam logic [11:0] OFF_BELOW_DECODE = 12'h017;
    localparam logic [11:0] OFF_UNDECODED    = 12'h500;
    localparam logic [11:0] LOWEST_DECODED   = 12'h018;

    // Configuration indexes that the block has no register for.
    localparam logic [CfgIndexW-1:0] REG_SPARE_LOW  = 2'd2;
    localparam logic [CfgIndexW-1:0] REG_SPARE_HIGH = 2'd3;

    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_REQUESTS = 175;
    localparam int RANDOM_PHASES  = 6;
    localparam int CYCLE_LIMIT    = 250000;
    localparam int REPORT_LIMIT   = 10;

    // One CPU cycle as the driver presents it on the request channel.
    typedef struct packed {
        logic                command;
        logic [CpuAddrW-1:0] cpu_address;
        logic [DataW-1:0]    write_data;
        logic [PpuAddrW-1:0] ppu_address;
    } cpu_cycle_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_data;

    cbm_request_if request_ch ();
    cbm_result_if  result_ch ();

    cartridge_bank_mapper_with_irq_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request_ch),
        .result       (result_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Mirror of the mapper state, kept in step with every accepted request.
    bank_t       prg_bank_tbl [PrgBanks];
    bank_t       chr_bank_tbl [ChrBanks];
    logic [1:0]  mirror_sel;
    logic [15:0] tick_count;
    logic        count_on;
    logic        irq_raised;
    bank_t       prg_mask;
    bank_t       chr_mask;

    cpu_cycle_t  cpu_cycles_q [$];     // requests waiting for the driver
    result_t     translations_due [$]; // predicted results, oldest first
    int          cycles_outstanding;   // requests queued whose result has not yet come back

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned write_requests;
    int unsigned tick_requests;
    int unsigned irq_events;
    int unsigned mask_settings;
    int unsigned counted_items;

    // Applies one CPU cycle to the mirrored state and returns the translation that the
    // block should report for it, as the state stands after the cycle.
    function automatic result_t mapper_step(input cpu_cycle_t c);
        logic [11:0] off;
        result_t     r;
        off = c.cpu_address[11:0];
        if (c.command == CMD_WRITE) begin
            if (c.cpu_address[15:12] == REG_PAGE && off >= LOWEST_DECODED) begin
                if (off == OFF_MIRROR_ONE) begin
                    mirror_sel = c.write_data[4] ? MIRROR_PAGE1 : MIRROR_PAGE0;
                end
                else if (off == OFF_MIRROR_TWO) begin
                    mirror_sel = c.write_data[4] ? MIRROR_HORIZONTAL : MIRROR_VERTICAL;
                end
                else if (off == OFF_IRQ_ACK) begin
                    count_on   = 1'b0;
                    irq_raised = 1'b0;
                end
                else if (off == OFF_COUNT_LOW) begin
                    tick_count[7:0] = c.write_data;
                    irq_raised      = 1'b0;
                end
                else if (off == OFF_COUNT_HIGH) begin
                    tick_count[15:8] = c.write_data;
                    count_on         = 1'b1;
                    irq_raised       = 1'b0;
                end
                else if (off >= OFF_PRG_FIRST && off <= OFF_PRG_LAST) begin
                    prg_bank_tbl[off[1:0]] = c.write_data;
                end
                else if (off >= OFF_CHR_FIRST && off <= OFF_CHR_LAST) begin
                    chr_bank_tbl[off[2:0]] = c.write_data;
                end
            end
        end
        else if (count_on && tick_count != 16'd0) begin
            // Stepping past the last count raises the line and parks the counter at zero.
            if (tick_count == COUNT_LAST) begin
                irq_raised = 1'b1;
                irq_events++;
            end
            tick_count = tick_count + 16'd1;
        end

        r = '0;
        r.irq_line = irq_raised;
        if (c.cpu_address[15]) begin
            r.prg_selected    = 1'b1;
            r.prg_rom_address = {prg_bank_tbl[c.cpu_address[14:13]] & prg_mask,
                                 c.cpu_address[12:0]};
        end
        if (!c.ppu_address[13]) begin
            r.chr_rom_address = {chr_bank_tbl[c.ppu_address[12:10]] & chr_mask,
                                 c.ppu_address[9:0]};
        end
        else begin
            case (mirror_sel)
                MIRROR_PAGE0:    r.nametable_page = 1'b0;
                MIRROR_PAGE1:    r.nametable_page = 1'b1;
                MIRROR_VERTICAL: r.nametable_page = c.ppu_address[10];
                default:         r.nametable_page = c.ppu_address[11];
            endcase
        end
        r.mirror_mode = mirror_sel;
        return r;
    endfunction

    // Driver: presents the next queued request when the channel is free, with random gaps.
    always @(posedge clk)
    begin : request_driver
        cpu_cycle_t pick;
        if (rst_n && (!request_ch.valid || request_ch.ready)) begin
            if (cpu_cycles_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                pick = cpu_cycles_q.pop_front();
                request_ch.valid       <= 1'b1;
                request_ch.command     <= pick.command;
                request_ch.cpu_address <= pick.cpu_address;
                request_ch.write_data  <= pick.write_data;
                request_ch.ppu_address <= pick.ppu_address;
            end
            else begin
                request_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: predicts on every accepted request and checks every accepted result.
    // Both handshakes are sampled here, so the prediction is queued before its result
    // is looked at, whatever order the simulator runs the clocked blocks in.
    always @(posedge clk)
    begin : result_monitor
        cpu_cycle_t taken;
        result_t    want;
        result_t    got;
        if (rst_n) begin
            if (request_ch.valid && request_ch.ready) begin
                taken.command     = request_ch.command;
                taken.cpu_address = request_ch.cpu_address;
                taken.write_data  = request_ch.write_data;
                taken.ppu_address = request_ch.ppu_address;
                if (taken.command == CMD_WRITE) begin
                    write_requests++;
                end
                else begin
                    tick_requests++;
                end
                translations_due.push_back(mapper_step(taken));
            end
            if (result_ch.valid && result_ch.ready) begin
                got.irq_line        = result_ch.irq_line;
                got.prg_selected    = result_ch.prg_selected;
                got.prg_rom_address = result_ch.prg_rom_address;
                got.chr_rom_address = result_ch.chr_rom_address;
                got.nametable_page  = result_ch.nametable_page;
                got.mirror_mode     = result_ch.mirror_mode;
                cycles_outstanding--;
                if (translations_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("Unexpected result with nothing outstanding: %p", got);
                    end
                end
                else begin
                    want = translations_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("Mismatch (expected / actual): irq %b/%b sel %b/%b",
                                     want.irq_line, got.irq_line,
                                     want.prg_selected, got.prg_selected);
                            $display("    prg %h/%h chr %h/%h page %b/%b mirror %0d/%0d",
                                     want.prg_rom_address, got.prg_rom_address,
                                     want.chr_rom_address, got.chr_rom_address,
                                     want.nametable_page, got.nametable_page,
                                     want.mirror_mode, got.mirror_mode);
                        end
                    end
                end
            end
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out with %0d results still outstanding", cycles_outstanding);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [PpuAddrW-1:0] any_ppu();
        return PpuAddrW'($urandom_range(16383));
    endfunction

    // Half the translated CPU addresses fall in the PRG window, half anywhere at all.
    function automatic logic [CpuAddrW-1:0] any_cpu();
        logic [CpuAddrW-1:0] a;
        a = CpuAddrW'($urandom_range(65535));
        if ($urandom_range(1) == 0) begin
            a[15] = 1'b1;
        end
        return a;
    endfunction

    function automatic logic [DataW-1:0] any_byte();
        return DataW'($urandom_range(255));
    endfunction

    task automatic send_cycle(input logic cmd, input logic [CpuAddrW-1:0] cpu,
                              input logic [DataW-1:0] data, input logic [PpuAddrW-1:0] ppu,
                              input bit counted);
        cpu_cycle_t c;
        c.command     = cmd;
        c.cpu_address = cpu;
        c.write_data  = data;
        c.ppu_address = ppu;
        cpu_cycles_q.push_back(c);
        cycles_outstanding++;
        if (counted) begin
            counted_items++;
        end
    endtask

    task automatic send_reg_write(input logic [11:0] off, input logic [DataW-1:0] data);
        send_cycle(CMD_WRITE, {REG_PAGE, off}, data, any_ppu(), 1'b1);
    endtask

    task automatic send_bank_write();
        if ($urandom_range(1) == 0) begin
            send_reg_write(OFF_PRG_FIRST + 12'($urandom_range(3)), any_byte());
        end
        else begin
            send_reg_write(OFF_CHR_FIRST + 12'($urandom_range(7)), any_byte());
        end
    endtask

    // Queues a burst of related requests: most load and run the counter or remap banks,
    // others set mirroring or only tick; a few are stray writes on the bus or register page.
    task automatic queue_random_burst();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(99);
        if (kind < 40) begin
            // Load the counter close to the top so that it can overflow within the burst.
            send_reg_write(OFF_COUNT_LOW,
                           ($urandom_range(3) == 0) ? any_byte()
                                                    : DataW'($urandom_range(8'hC0, 8'hFF)));
            if ($urandom_range(7) != 0) begin
                send_reg_write(OFF_COUNT_HIGH,
                               ($urandom_range(3) == 0) ? any_byte() : 8'hFF);
            end
            n = $urandom_range(1, 80);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(15) == 0) begin
                    send_bank_write();
                end
                else begin
                    send_cycle(CMD_TICK, any_cpu(), any_byte(), any_ppu(), 1'b1);
                end
            end
            if ($urandom_range(1) == 0) begin
                send_reg_write(OFF_IRQ_ACK, any_byte());
            end
        end
        else if (kind < 65) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                send_bank_write();
            end
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                send_cycle(CMD_TICK, any_cpu(), any_byte(), any_ppu(), 1'b1);
            end
        end
        else if (kind < 75) begin
            send_reg_write(($urandom_range(1) == 0) ? OFF_MIRROR_ONE : OFF_MIRROR_TWO,
                           any_byte());
            send_cycle(CMD_TICK, any_cpu(), any_byte(), 14'h2000 | any_ppu(), 1'b1);
        end
        else if (kind < 90) begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
                send_cycle(CMD_TICK, any_cpu(), any_byte(), any_ppu(), 1'b1);
            end
        end
        else begin
            // Stray writes: anywhere on the bus, or at any offset of the register page.
            if ($urandom_range(1) == 0) begin
                send_cycle(CMD_WRITE, CpuAddrW'($urandom_range(65535)), any_byte(),
                           any_ppu(), 1'b0);
            end
            else begin
                send_cycle(CMD_WRITE, {REG_PAGE, 12'($urandom_range(4095))},
                           any_byte(), any_ppu(), 1'b0);
            end
        end
    endtask

    // Waits until every queued request has produced its result, then lets the bench settle.
    task automatic wait_until_drained();
        while (cycles_outstanding != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Configuration writes happen only while the mapper has nothing in flight.
    task automatic write_mask(input logic [CfgIndexW-1:0] idx,
                              input logic [CfgDataW-1:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == REG_PRG_BANK_MASK) begin
            prg_mask = value;
        end
        else if (idx == REG_CHR_BANK_MASK) begin
            chr_mask = value;
        end
    endtask

    initial
    begin
        logic [CfgDataW-1:0] prg_value;
        logic [CfgDataW-1:0] chr_value;

        // Every input is at a known level from time zero.
        rst_n                  = 1'b0;
        cfg_write_en           = 1'b0;
        cfg_index              = REG_PRG_BANK_MASK;
        cfg_data               = '0;
        request_ch.valid       = 1'b0;
        request_ch.command     = CMD_TICK;
        request_ch.cpu_address = '0;
        request_ch.write_data  = '0;
        request_ch.ppu_address = '0;
        result_ch.ready        = 1'b0;

        // Predictor starts from the state the block resets to.
        prg_bank_tbl = PRG_BANK_RESET;
        for (int i = 0; i < ChrBanks; i++) begin
            chr_bank_tbl[i] = bank_t'(i);
        end
        mirror_sel         = MIRROR_PAGE0;
        tick_count         = '0;
        count_on           = 1'b0;
        irq_raised         = 1'b0;
        prg_mask           = PRG_MASK_RESET;
        chr_mask           = CHR_MASK_RESET;
        cycles_outstanding = 0;
        mismatches         = 0;
        cycle_count        = 0;
        write_requests     = 0;
        tick_requests      = 0;
        irq_events         = 0;
        mask_settings      = 1;
        counted_items      = 0;
        send_idle_pct      = 6;
        recv_idle_pct      = 80;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests with the reset masks: address extremes, each mirroring mode
        // including the palette range, bank writes at both ends of each table, ignored
        // writes, and a counter run through the top and on past it.
        send_cycle(CMD_TICK, 16'h0000, 8'h00, 14'h0000, 1'b1);
        send_cycle(CMD_TICK, 16'hFFFF, 8'hFF, 14'h3FFF, 1'b1);
        send_cycle(CMD_TICK, 16'h8000, 8'h00, 14'h1FFF, 1'b1);
        send_cycle(CMD_TICK, 16'h7FFF, 8'h00, 14'h2000, 1'b1);
        send_reg_write(OFF_MIRROR_ONE, 8'h10);
        send_cycle(CMD_WRITE, {REG_PAGE, OFF_MIRROR_TWO}, 8'h00, 14'h2400, 1'b1);
        send_cycle(CMD_WRITE, {REG_PAGE, OFF_MIRROR_TWO}, 8'hFF, 14'h2800, 1'b1);
        send_cycle(CMD_TICK, 16'hC000, 8'h00, 14'h3F1F, 1'b1);
        send_reg_write(OFF_MIRROR_ONE, 8'hEF);
        send_reg_write(OFF_PRG_FIRST, 8'hFF);
        send_reg_write(OFF_PRG_LAST, 8'h00);
        send_reg_write(OFF_CHR_FIRST, 8'hFF);
        send_reg_write(OFF_CHR_LAST, 8'h80);
        send_cycle(CMD_TICK, 16'h8123, 8'h00, 14'h0123, 1'b1);
        send_cycle(CMD_TICK, 16'hFFFF, 8'h00, 14'h1FFF, 1'b1);
        send_reg_write(OFF_BELOW_DECODE, 8'hFF);
        send_cycle(CMD_WRITE, {~REG_PAGE, OFF_PRG_FIRST}, 8'h12, 14'h0400, 1'b1);
        send_reg_write(OFF_UNDECODED, 8'h12);
        send_reg_write(OFF_COUNT_LOW, 8'hFE);
        send_reg_write(OFF_COUNT_HIGH, 8'hFF);
        // A write cycle must not advance the counter.
        send_reg_write(OFF_PRG_FIRST + 12'd1, 8'h33);
        send_cycle(CMD_TICK, 16'hA000, 8'h00, 14'h0800, 1'b1);
        send_cycle(CMD_TICK, 16'hE000, 8'h00, 14'h1000, 1'b1);
        send_cycle(CMD_TICK, 16'h0000, 8'h00, 14'h1400, 1'b1);
        send_reg_write(OFF_IRQ_ACK, 8'h00);
        // Enabled with a zero count: the counter must stay put.
        send_reg_write(OFF_COUNT_HIGH, 8'h00);
        send_cycle(CMD_TICK, 16'h9FFF, 8'h00, 14'h1800, 1'b1);
        wait_until_drained();

        // The spare indexes must leave both masks alone.
        write_mask(REG_SPARE_LOW, CfgDataW'($urandom_range(255)));
        write_mask(REG_SPARE_HIGH, CfgDataW'($urandom_range(255)));

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       begin prg_value = 8'd0;   chr_value = 8'd0;   end
                1:       begin prg_value = 8'd255; chr_value = 8'd255; end
                2:       begin prg_value = 8'd7;   chr_value = 8'd15;  end
                3:       begin prg_value = 8'd255; chr_value = 8'd0;   end
                4:       begin prg_value = 8'd0;   chr_value = 8'd255; end
                default:
                begin
                    prg_value = CfgDataW'((1 << $urandom_range(8)) - 1);
                    chr_value = CfgDataW'((1 << $urandom_range(8)) - 1);
                end
            endcase
            write_mask(REG_PRG_BANK_MASK, prg_value);
            write_mask(REG_CHR_BANK_MASK, chr_value);
            mask_settings++;

            // Sender lightly idle and receiver heavily stalled first, then the reverse,
            // then both running flat out.
            if (p < 2) begin
                send_idle_pct = 6;
                recv_idle_pct = 80;
            end
            else if (p < 4) begin
                send_idle_pct = 80;
                recv_idle_pct = 6;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            counted_items = 0;
            while (counted_items < PHASE_REQUESTS) begin
                queue_random_burst();
            end
            // The sender holds back here until every result of the phase is in.
            wait_until_drained();
        end

        if (translations_due.size() != 0) begin
            mismatches += translations_due.size();
            $display("%0d predicted results never arrived", translations_due.size());
        end

        $display("Covered %0d requests (%0d CPU writes, %0d ticks) under %0d mask settings,",
                 write_requests + tick_requests, write_requests, tick_requests, mask_settings);
        $display("with %0d counter overflows raising the interrupt; %0d mismatches.",
                 irq_events, mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end
        else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
